FILE: rtl/blkmap_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blkmap_pkg
// Shared types and constants of the block owner allocation map: opcodes,
// status codes, sequencer states and the owner entry held in each cell.
// ----------------------------------------------------------------------------
package blkmap_pkg;

    // default sizes
    localparam int BLK_DEPTH_DEF = 64;
    localparam int MAX_FILES_DEF = 16;

    // internal widths, sized for the largest parameter values
    localparam int OWN_W = 6;
    localparam int CNT_W = 7;
    localparam int FT_W  = 7;

    // register reset values
    localparam logic [16:0] BLOCK_SIZE_RST  = 17'd512;
    localparam logic [6:0]  BLOCK_COUNT_RST = 7'd64;

    // register selects on the configuration port
    localparam logic REG_BLOCK_SIZE  = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_LIST = 2'd2,
        OP_STAT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BIG      = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_ACT,
        S_SHIFT,
        S_ONE
    } t_state;

    // one owner table entry
    typedef struct packed {
        logic             used;
        logic [OWN_W-1:0] owner;
    } t_entry;

endpackage
`default_nettype wire

FILE: rtl/block_owner_allocation_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_owner_allocation_map
// Owner map of storage blocks with add, delete, list and status operations.
// ----------------------------------------------------------------------------
// One item at a time. The owner table is a ring of BLK_DEPTH cells that
// rotates past a single control point, so each operation makes a counting
// lap of the ring (the divider for the block count runs alongside), then
// either an update lap that writes or hands out blocks as the ring passes
// (add and list with blocks, delete) or a lone result; a delete then moves
// the later size entries down, reading and writing each in turn, before its
// lone result. Output stall pauses the ring while an add or list block
// result waits. No clearing pass is needed after reset.
module block_owner_allocation_map #(
    parameter int BLK_DEPTH = blkmap_pkg::BLK_DEPTH_DEF,
    parameter int MAX_FILES = blkmap_pkg::MAX_FILES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input items
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [3:0]  i_file_index,
    input  wire logic [31:0] i_file_size,
    // result items
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [3:0]       o_owner_index,
    output logic [5:0]       o_blk_idx,
    output logic             o_block_valid,
    output logic             o_last,
    output logic [6:0]       o_free_blk,
    output logic [31:0]      o_stored_size,
    output logic [35:0]      o_bytes_used,
    output logic [22:0]      o_bytes_free
);
    import blkmap_pkg::*;

    localparam int SA_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

    // registers
    logic [16:0]      r_block_size;
    logic [6:0]       r_block_count;
    t_state           r_state, n_state;
    t_op              r_op;
    logic [3:0]       r_fidx;
    logic [31:0]      r_fsize;
    logic [CNT_W-1:0] r_pos;
    logic             r_cnt_done;
    logic [CNT_W-1:0] r_free;
    logic [CNT_W-1:0] r_match;
    logic [CNT_W-1:0] r_lastblk;
    logic             r_has;
    logic [FT_W-1:0]  r_ft;
    logic [35:0]      r_bt;
    logic [23:0]      r_cap;
    logic [CNT_W-1:0] r_need;
    logic [CNT_W-1:0] r_n;
    logic [FT_W-1:0]  r_si;
    logic             r_sph;
    logic [31:0]      r_rd;
    logic [1:0]       r_st;
    logic [OWN_W-1:0] r_own;
    logic [CNT_W-1:0] r_fb;
    logic [31:0]      r_sz;
    logic [31:0]      r_size_mem [MAX_FILES];

    logic             r_ov;
    logic [1:0]       r_o_status;
    logic [3:0]       r_o_owner;
    logic [5:0]       r_o_blk;
    logic             r_o_bvalid;
    logic             r_o_last;
    logic [6:0]       r_o_fblocks;
    logic [31:0]      r_o_size;
    logic [35:0]      r_o_used;
    logic [22:0]      r_o_fbytes;

    // combinational
    t_entry           ring_q [BLK_DEPTH];
    t_entry           head;
    t_entry           wb;
    logic             ring_en;
    logic             emit;
    logic             em_valid;
    logic             em_last;
    logic             mem_we;
    logic [FT_W-1:0]  mem_wa;
    logic [31:0]      mem_wd;
    logic [FT_W-1:0]  rd_addr;
    logic             in_acc;
    logic             out_free;
    logic             pos_last;
    logic [CNT_W-1:0] lim;
    logic             in_lim;
    logic [16:0]      bs_eff;
    logic             cfg_wr;
    logic             div_done;
    logic [31:0]      div_quot;
    logic             div_rem_nz;
    logic [31:0]      d_need;
    logic             d_full;
    logic             d_big;
    logic             d_nf;
    logic             dec_go;
    logic             add_ok;
    logic             is_match;
    logic [35:0]      cap_ext;
    logic [35:0]      fbytes;

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= BLOCK_SIZE_RST;
            r_block_count <= BLOCK_COUNT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BLOCK_SIZE) begin
                r_block_size <= pwdata[16:0];
            end else begin
                r_block_count <= pwdata[6:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_BLOCK_COUNT) begin
            prdata = {25'd0, r_block_count};
        end else begin
            prdata = {15'd0, r_block_size};
        end
    end

    // handshake helpers
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ov || !i_out_stall;
    assign pos_last   = (r_pos == CNT_W'(BLK_DEPTH - 1));
    assign lim        = (r_block_count > CNT_W'(BLK_DEPTH)) ? CNT_W'(BLK_DEPTH)
                                                           : r_block_count;
    assign in_lim     = (r_pos < lim);
    assign bs_eff     = (r_block_size == '0) ? 17'd1 : r_block_size;

    // owner ring
    assign head = ring_q[0];

    genvar g;
    generate
        for (g = 0; g < BLK_DEPTH; g++) begin : g_cell
            t_entry nxt;
            if (g == BLK_DEPTH - 1) begin : g_tail
                assign nxt = wb;
            end else begin : g_mid
                assign nxt = ring_q[g + 1];
            end
            blkmap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (ring_en),
                .i_entry (nxt),
                .o_entry (ring_q[g])
            );
        end
    endgenerate

    // block count divider
    blkmap_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_dividend (i_file_size),
        .i_divisor  (bs_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem_nz   (div_rem_nz)
    );

    // decision at the end of the counting lap
    assign d_need = div_quot + {31'd0, div_rem_nz};
    assign d_full = (r_ft >= FT_W'(MAX_FILES));
    assign d_big  = (d_need > {{(32 - CNT_W){1'b0}}, r_free});
    assign d_nf   = ({{(FT_W - 4){1'b0}}, r_fidx} >= r_ft);
    assign dec_go = (r_state == S_COUNT) && r_cnt_done && div_done;
    assign add_ok = (r_op == OP_ADD) && !d_full && !d_big;
    assign is_match = head.used && (head.owner == OWN_W'(r_fidx));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_COUNT;
            end
            S_COUNT: begin
                if (dec_go) begin
                    case (r_op)
                        OP_ADD:  n_state = (add_ok && d_need != '0) ? S_ACT : S_ONE;
                        OP_DEL:  n_state = d_nf ? S_ONE : S_ACT;
                        OP_LIST: n_state = (d_nf || !r_has) ? S_ONE : S_ACT;
                        default: n_state = S_ONE;
                    endcase
                end
            end
            S_ACT: begin
                if (ring_en && pos_last) begin
                    n_state = (r_op == OP_DEL) ? S_SHIFT : S_IDLE;
                end
            end
            S_SHIFT: begin
                if (r_si >= r_ft) n_state = S_ONE;
            end
            S_ONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ring write-back, result emission and size memory access
    always_comb begin
        ring_en  = 1'b0;
        wb       = head;
        emit     = 1'b0;
        em_valid = 1'b0;
        em_last  = 1'b1;
        mem_we   = 1'b0;
        mem_wa   = r_ft;
        mem_wd   = r_fsize;
        rd_addr  = {{(FT_W - 4){1'b0}}, r_fidx};
        case (r_state)
            S_COUNT: begin
                ring_en = !r_cnt_done;
                mem_we  = dec_go && add_ok;
            end
            S_ACT: begin
                case (r_op)
                    OP_ADD: begin
                        if (in_lim && !head.used && (r_n < r_need)) begin
                            wb.used  = 1'b1;
                            wb.owner = r_own;
                            emit     = 1'b1;
                            em_valid = 1'b1;
                            em_last  = ((r_n + CNT_W'(1)) == r_need);
                        end
                        ring_en = !emit || out_free;
                    end
                    OP_DEL: begin
                        if (is_match) begin
                            wb.used = 1'b0;
                        end else if (head.used && (head.owner > OWN_W'(r_fidx))) begin
                            wb.owner = head.owner - OWN_W'(1);
                        end
                        ring_en = 1'b1;
                    end
                    OP_LIST: begin
                        emit     = is_match;
                        em_valid = is_match;
                        em_last  = (r_pos == r_lastblk);
                        ring_en  = !emit || out_free;
                    end
                    default: ring_en = 1'b1;
                endcase
            end
            S_SHIFT: begin
                rd_addr = r_si + FT_W'(1);
                mem_we  = r_sph && (r_si < r_ft);
                mem_wa  = r_si;
                mem_wd  = r_rd;
            end
            S_ONE: begin
                emit = 1'b1;
            end
            default: begin
                ring_en = 1'b0;
            end
        endcase
    end

    // file size memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_size_mem[mem_wa[SA_W-1:0]] <= mem_wd;
        end
        r_rd <= r_size_mem[rd_addr[SA_W-1:0]];
    end

    // capacity in bytes of the usable blocks, a zero block size gives none
    always_ff @(posedge i_clk) begin
        r_cap <= {17'd0, lim} * {7'd0, r_block_size};
    end

    // sequencer and file state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_cnt_done <= 1'b0;
            r_ft       <= '0;
            r_bt       <= '0;
        end else begin
            r_state <= n_state;
            if (ring_en) begin
                r_pos <= pos_last ? '0 : r_pos + CNT_W'(1);
            end
            if (in_acc) begin
                r_cnt_done <= 1'b0;
            end else if (r_state == S_COUNT && ring_en && pos_last) begin
                r_cnt_done <= 1'b1;
            end
            if (dec_go) begin
                if (add_ok) begin
                    r_ft <= r_ft + FT_W'(1);
                    r_bt <= r_bt + {4'd0, r_fsize};
                end else if (r_op == OP_DEL && !d_nf) begin
                    r_ft <= r_ft - FT_W'(1);
                    r_bt <= r_bt - {4'd0, r_rd};
                end
            end
        end
    end

    // item operands, lap counters and shared result fields
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op      <= t_op'(i_opcode);
            r_fidx    <= i_file_index;
            r_fsize   <= i_file_size;
            r_free    <= '0;
            r_match   <= '0;
            r_has     <= 1'b0;
            r_lastblk <= '0;
        end else if (r_state == S_COUNT && ring_en) begin
            if (in_lim && !head.used) r_free <= r_free + CNT_W'(1);
            if (in_lim && is_match) r_match <= r_match + CNT_W'(1);
            if (is_match) begin
                r_has     <= 1'b1;
                r_lastblk <= r_pos;
            end
        end
        if (dec_go) begin
            r_n    <= '0;
            r_need <= d_need[CNT_W-1:0];
            r_si   <= {{(FT_W - 4){1'b0}}, r_fidx};
            r_sph  <= 1'b0;
            r_st   <= ST_OK;
            r_own  <= '0;
            r_fb   <= r_free;
            r_sz   <= '0;
            case (r_op)
                OP_ADD: begin
                    if (d_full) begin
                        r_st <= ST_FULL;
                    end else if (d_big) begin
                        r_st <= ST_BIG;
                    end else begin
                        r_own <= OWN_W'(r_ft);
                        r_fb  <= r_free - d_need[CNT_W-1:0];
                        r_sz  <= r_fsize;
                    end
                end
                OP_DEL: begin
                    r_own <= OWN_W'(r_fidx);
                    if (d_nf) begin
                        r_st <= ST_NOTFOUND;
                    end else begin
                        r_fb <= r_free + r_match;
                    end
                end
                OP_LIST: begin
                    r_own <= OWN_W'(r_fidx);
                    if (d_nf) begin
                        r_st <= ST_NOTFOUND;
                    end else begin
                        r_sz <= r_rd;
                    end
                end
                default: r_st <= ST_OK;
            endcase
        end else begin
            if (r_state == S_ACT && emit && out_free) r_n <= r_n + CNT_W'(1);
            if (r_state == S_SHIFT) begin
                r_sph <= !r_sph;
                if (r_sph) r_si <= r_si + FT_W'(1);
            end
        end
    end

    // free bytes from capacity and byte total
    assign cap_ext = {12'd0, r_cap};
    assign fbytes  = (cap_ext > r_bt) ? (cap_ext - r_bt) : 36'd0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit && out_free) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && out_free) begin
            r_o_status  <= r_st;
            r_o_owner   <= r_own[3:0];
            r_o_blk     <= em_valid ? r_pos[5:0] : 6'd0;
            r_o_bvalid  <= em_valid;
            r_o_last    <= em_last;
            r_o_fblocks <= r_fb;
            r_o_size    <= r_sz;
            r_o_used    <= r_bt;
            r_o_fbytes  <= fbytes[22:0];
        end
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_o_status;
    assign o_owner_index = r_o_owner;
    assign o_blk_idx     = r_o_blk;
    assign o_block_valid = r_o_bvalid;
    assign o_last        = r_o_last;
    assign o_free_blk    = r_o_fblocks;
    assign o_stored_size = r_o_size;
    assign o_bytes_used  = r_o_used;
    assign o_bytes_free  = r_o_fbytes;

`ifndef SYNTH
    // ring is back in line whenever the block is idle
    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pos == '0))
        else $error("owner ring not aligned while idle");

    // file count never passes the file table size
    a_ft_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ft <= FT_W'(MAX_FILES))
        else $error("file count beyond table size");

    // free block count stays within the table
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_free_blk <= CNT_W'(BLK_DEPTH)))
        else $error("free block count beyond table depth");

    // an accepted item closes the input until it is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input open right after an item");
`endif

endmodule
`default_nettype wire

FILE: rtl/blkmap_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blkmap_cell
// One entry of the owner ring: takes its neighbour's entry on each shift.
// ----------------------------------------------------------------------------
module blkmap_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_shift,
    input  wire blkmap_pkg::t_entry  i_entry,
    output blkmap_pkg::t_entry       o_entry
);
    import blkmap_pkg::*;

    logic             r_used;
    logic [OWN_W-1:0] r_owner;

    // used flag, cleared at reset so every block starts free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_shift) begin
            r_used <= i_entry.used;
        end
    end

    // owner payload
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_owner <= i_entry.owner;
        end
    end

    assign o_entry.used  = r_used;
    assign o_entry.owner = r_owner;

endmodule
`default_nettype wire

FILE: rtl/blkmap_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blkmap_div
// Restoring divider, one quotient bit a cycle: 32 bit size by block size.
// ----------------------------------------------------------------------------
module blkmap_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [16:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quot,
    output logic             o_rem_nz
);
    import blkmap_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [16:0] r_rem;
    logic [31:0] r_q;
    logic [16:0] r_dvs;

    logic [17:0] trial;
    logic        qbit;
    logic [17:0] diff;

    // one trial subtraction
    always_comb begin
        trial = {r_rem, r_q[31]};
        diff  = trial - {1'b0, r_dvs};
        qbit  = (trial >= {1'b0, r_dvs});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[16:0] : trial[16:0];
            r_q   <= {r_q[30:0], qbit};
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_q;
    assign o_rem_nz = (r_rem != '0);

endmodule
`default_nettype wire
